>>> sv/klsr_pkg.sv
// shared types and codes for the keymap layer stack resolver
// no dependencies; used by keymap_layer_stack_resolver_core
package klsr_pkg;

  // keymap entry kinds as held in the store
  typedef enum logic [2:0] {
    ET_TRANSPARENT = 3'd0,
    ET_KEY         = 3'd1,
    ET_MOMENTARY   = 3'd2,
    ET_TOGGLE      = 3'd3,
    ET_ON          = 3'd4,
    ET_OFF         = 3'd5,
    ET_DEFAULT     = 3'd6,
    ET_LAYERMOD    = 3'd7
  } entry_type_e;

  // result kinds
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LAYER   = 3'd3,
    EV_INVALID = 3'd4,
    EV_WRITE   = 3'd5
  } event_kind_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_LAYERS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_KEYS   = 1'b1;

  // fixed field widths
  localparam int unsigned KIND_BITS   = 3;
  localparam int unsigned KEY_BITS    = 7;
  localparam int unsigned ELAYER_BITS = 3;
  localparam int unsigned EVALUE_BITS = 16;
  localparam int unsigned CODE_BITS   = 16;
  localparam int unsigned ALAYER_BITS = 3;

endpackage

>>> sv/klsr_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module klsr_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/keymap_layer_stack_resolver_core.sv
// keyboard layer engine: keymap store of layers by keys plus an active-layer stack
// depends on klsr_pkg and klsr_ram (keymap store)
// a write item goes straight to its result; a key event walks the stack from the top layer down,
//   then a toggle rebuilds the stack over the layers in use and a momentary searches it
// throughput: one item at a time; next item taken the cycle after the result registers
// reset: async active low; then a clearing pass over all LAYERS*KEYS store entries stalls items
module keymap_layer_stack_resolver_core #(
  parameter int LAYERS        = 8,
  parameter int KEYS          = 128,
  parameter int KEY_CODE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input items
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   action_i,
  input  logic [klsr_pkg::KEY_BITS-1:0]          key_index_i,
  input  logic                                   pressed_i,
  input  logic [klsr_pkg::ELAYER_BITS-1:0]       entry_layer_i,
  input  logic [klsr_pkg::KIND_BITS-1:0]         entry_type_i,
  input  logic [klsr_pkg::EVALUE_BITS-1:0]       entry_value_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [klsr_pkg::KIND_BITS-1:0]         event_kind_o,
  output logic [klsr_pkg::CODE_BITS-1:0]         key_code_o,
  output logic [klsr_pkg::ALAYER_BITS-1:0]       active_layer_o,
  // configuration writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [klsr_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [7:0]                             cfg_data_i
);

  // sizes
  localparam int DEPTH = LAYERS * KEYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;  // layer number / stack index
  localparam int DW    = $clog2(LAYERS + 1);                  // stack depth, walk index
  localparam int NW    = $clog2(LAYERS + 1);                  // layers in use
  localparam int EW    = klsr_pkg::KIND_BITS + KEY_CODE_BITS; // store entry

  // sequencer codes
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_WRITE   = 4'd2;
  localparam logic [3:0] S_WALK    = 4'd3;
  localparam logic [3:0] S_RDATA   = 4'd4;
  localparam logic [3:0] S_ACT     = 4'd5;
  localparam logic [3:0] S_REBUILD = 4'd6;
  localparam logic [3:0] S_SEARCH  = 4'd7;
  localparam logic [3:0] S_SHIFT   = 4'd8;
  localparam logic [3:0] S_TOPSET  = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  logic [3:0]               state_q, state_d;
  logic [DW-1:0]            idx_q, idx_d;
  logic [DW-1:0]            depth_q, depth_d;
  logic [LAYERS-1:0]        toggled_q, toggled_d;
  logic [LW-1:0]            default_q, default_d;
  logic [LW-1:0]            stack_q [LAYERS];
  logic [AW-1:0]            clr_q;

  // stack write port
  logic                     st_we;
  logic [LW-1:0]            st_widx;
  logic [LW-1:0]            st_wdata;
  logic [LW-1:0]            stack_rd;

  // configuration
  logic [3:0]               num_layers_q;
  logic [7:0]               num_keys_q;
  logic [NW-1:0]            n_used;

  // latched item
  logic [klsr_pkg::KEY_BITS-1:0]    key_q;
  logic                     pressed_q;
  logic [klsr_pkg::ELAYER_BITS-1:0] elayer_q;
  logic [klsr_pkg::KIND_BITS-1:0]   etype_q;
  logic [klsr_pkg::EVALUE_BITS-1:0] evalue_q;

  // found entry and pending result
  klsr_pkg::entry_type_e    kind_q;
  klsr_pkg::entry_type_e    rd_kind;
  logic [KEY_CODE_BITS-1:0] val_q;
  klsr_pkg::event_kind_e    ev_q, ev_d;
  logic [KEY_CODE_BITS-1:0] code_q, code_d;

  // keymap store port
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [EW-1:0]            ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [EW-1:0]            ram_rdata;

  // output register
  logic                     out_valid_q;
  logic                     out_load;
  klsr_pkg::event_kind_e    out_kind_q;
  logic [klsr_pkg::CODE_BITS-1:0]   out_code_q;
  logic [klsr_pkg::ALAYER_BITS-1:0] out_layer_q;

  // misc decode
  logic                     accept;
  logic                     key_ok;
  logic                     wr_ok;
  logic                     layer_ok;
  logic                     val_ok;
  logic [LW-1:0]            tl;
  logic                     tl_on;
  logic                     flip_ok;
  logic [DW-1:0]            idx_m1;
  logic [31:0]              code_w;
  logic [31:0]              top_w;

  // store reads and writes go through one ram
  klsr_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // layers in use, saturated to 1..LAYERS
  always_comb begin
    if (num_layers_q == 4'd0) begin
      n_used = NW'(1);
    end else if (32'(num_layers_q) > LAYERS) begin
      n_used = NW'(LAYERS);
    end else begin
      n_used = NW'(num_layers_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  // one stack read port, always at the sequencer index
  assign stack_rd = stack_q[idx_q[LW-1:0]];
  assign idx_m1   = idx_q - DW'(1);

  assign key_ok   = ({1'b0, key_index_i} < num_keys_q) && (32'(key_index_i) < KEYS);
  assign wr_ok    = (32'(elayer_q) < LAYERS) && (32'(key_q) < KEYS);
  // stack layers at or above the layers in use read as transparent
  assign layer_ok = 32'(stack_rd) < 32'(n_used);
  assign val_ok   = 32'(val_q) < 32'(n_used);
  assign tl       = val_q[LW-1:0];
  assign tl_on    = toggled_q[tl];
  assign rd_kind  = klsr_pkg::entry_type_e'(ram_rdata[EW-1:KEY_CODE_BITS]);

  // toggle, on and off flip the target bit and rebuild on a press: on only if clear, off only if set
  assign flip_ok  = pressed_q && ((kind_q == klsr_pkg::ET_TOGGLE) ||
                                  ((kind_q == klsr_pkg::ET_ON) && !tl_on) ||
                                  ((kind_q == klsr_pkg::ET_OFF) && tl_on));

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    depth_d   = depth_q;
    toggled_d = toggled_q;
    default_d = default_q;
    ev_d      = ev_q;
    code_d    = code_q;
    st_we     = 1'b0;
    st_widx   = idx_q[LW-1:0];
    st_wdata  = stack_rd;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_raddr = AW'(32'(stack_rd) * KEYS + 32'(key_q));
    out_load  = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        // transparent entries everywhere
        ram_we = 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          code_d = '0;
          if (action_i) begin
            ev_d    = klsr_pkg::EV_WRITE;
            state_d = S_WRITE;
          end else if (!key_ok) begin
            ev_d    = klsr_pkg::EV_INVALID;
            state_d = S_TOPSET;
          end else if (depth_q == '0) begin
            ev_d    = klsr_pkg::EV_NONE;
            state_d = S_TOPSET;
          end else begin
            ev_d    = klsr_pkg::EV_NONE;
            idx_d   = depth_q - DW'(1);
            state_d = S_WALK;
          end
        end
      end
      S_WRITE: begin
        // writes outside the store are dropped but still reported
        ram_we    = wr_ok;
        ram_waddr = AW'(32'(elayer_q) * KEYS + 32'(key_q));
        ram_wdata = {etype_q, KEY_CODE_BITS'(32'(evalue_q))};
        state_d   = S_TOPSET;
      end
      S_WALK: begin
        if (layer_ok) begin
          state_d = S_RDATA;
        end else if (idx_q == '0) begin
          state_d = S_TOPSET;
        end else begin
          idx_d = idx_m1;
        end
      end
      S_RDATA: begin
        if (rd_kind != klsr_pkg::ET_TRANSPARENT) begin
          state_d = S_ACT;
        end else if (idx_q == '0) begin
          state_d = S_TOPSET;
        end else begin
          idx_d   = idx_m1;
          state_d = S_WALK;
        end
      end
      S_ACT: begin
        state_d = S_TOPSET;
        if (kind_q == klsr_pkg::ET_KEY) begin
          code_d = val_q;
          ev_d   = pressed_q ? klsr_pkg::EV_PRESS : klsr_pkg::EV_RELEASE;
        end else if (val_ok) begin
          unique case (kind_q) inside
            klsr_pkg::ET_MOMENTARY, klsr_pkg::ET_LAYERMOD: begin
              idx_d   = '0;
              state_d = S_SEARCH;
            end
            klsr_pkg::ET_TOGGLE, klsr_pkg::ET_ON, klsr_pkg::ET_OFF: begin
              if (flip_ok) begin
                toggled_d = toggled_q ^ (LAYERS'(1) << tl);
                st_we     = 1'b1;
                st_widx   = '0;
                st_wdata  = default_q;
                depth_d   = DW'(1);
                idx_d     = '0;
                ev_d      = klsr_pkg::EV_LAYER;
                state_d   = S_REBUILD;
              end
            end
            klsr_pkg::ET_DEFAULT: begin
              if (pressed_q) begin
                default_d = tl;
                st_we     = 1'b1;
                st_widx   = '0;
                st_wdata  = tl;
                depth_d   = DW'(1);
                toggled_d = LAYERS'(1) << tl;
                ev_d      = klsr_pkg::EV_LAYER;
              end
            end
            default: begin
              state_d = S_TOPSET;
            end
          endcase
        end
      end
      S_REBUILD: begin
        // default layer first, then toggled layers in index order
        if (toggled_q[idx_q[LW-1:0]] && (idx_q[LW-1:0] != default_q) &&
            (depth_q < DW'(LAYERS))) begin
          st_we    = 1'b1;
          st_widx  = depth_q[LW-1:0];
          st_wdata = idx_q[LW-1:0];
          depth_d  = depth_q + DW'(1);
        end
        if (32'(idx_q) + 32'd1 == 32'(n_used)) begin
          state_d = S_TOPSET;
        end else begin
          idx_d = idx_q + DW'(1);
        end
      end
      S_SEARCH: begin
        if (idx_q == depth_q) begin
          // absent: push on press when there is room
          if (pressed_q && (depth_q < DW'(LAYERS))) begin
            st_we    = 1'b1;
            st_widx  = depth_q[LW-1:0];
            st_wdata = tl;
            depth_d  = depth_q + DW'(1);
          end
          state_d = S_TOPSET;
        end else if (stack_rd == tl) begin
          if (pressed_q) begin
            state_d = S_TOPSET;
          end else begin
            idx_d   = idx_q + DW'(1);
            state_d = S_SHIFT;
          end
        end else begin
          idx_d = idx_q + DW'(1);
        end
      end
      S_SHIFT: begin
        // close the gap left by the released layer
        if (idx_q < depth_q) begin
          st_we    = 1'b1;
          st_widx  = idx_m1[LW-1:0];
          st_wdata = stack_rd;
          idx_d    = idx_q + DW'(1);
        end else begin
          depth_d = depth_q - DW'(1);
          state_d = S_TOPSET;
        end
      end
      S_TOPSET: begin
        idx_d   = depth_q - DW'(1);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idx_q        <= '0;
      depth_q      <= DW'(1);
      toggled_q    <= LAYERS'(1);
      default_q    <= '0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
      num_layers_q <= 4'd1;
      num_keys_q   <= 8'd128;
      for (int i = 0; i < LAYERS; i++) begin
        stack_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      depth_q   <= depth_d;
      toggled_q <= toggled_d;
      default_q <= default_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (st_we) begin
        stack_q[st_widx] <= st_wdata;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          klsr_pkg::CFG_NUM_LAYERS: num_layers_q <= cfg_data_i[3:0];
          klsr_pkg::CFG_NUM_KEYS:   num_keys_q   <= cfg_data_i;
          default:                  num_keys_q   <= num_keys_q;
        endcase
      end
    end
  end

  assign code_w = 32'(code_q);
  assign top_w  = 32'(stack_rd);

  // payload registers
  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    code_q <= code_d;
    if (accept) begin
      key_q     <= key_index_i;
      pressed_q <= pressed_i;
      elayer_q  <= entry_layer_i;
      etype_q   <= entry_type_i;
      evalue_q  <= entry_value_i;
    end
    if (state_q == S_RDATA) begin
      kind_q <= rd_kind;
      val_q  <= ram_rdata[KEY_CODE_BITS-1:0];
    end
    if (out_load) begin
      out_kind_q  <= ev_q;
      out_code_q  <= code_w[klsr_pkg::CODE_BITS-1:0];
      out_layer_q <= (depth_q == '0) ? '0 : top_w[klsr_pkg::ALAYER_BITS-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = out_kind_q;
  assign key_code_o     = out_code_q;
  assign active_layer_o = out_layer_q;

`ifndef SYNTH
  // a write item never starts a stack walk
  a_write_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> (state_q == S_TOPSET) && (depth_q == $past(depth_q)))
    else $error("write item changed the layer stack");

  // the stack never grows past its storage
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(LAYERS))
    else $error("layer stack depth out of range");

  // a layer change always leaves the default layer at the bottom
  a_layer_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && (ev_q == klsr_pkg::EV_LAYER)) |->
      (depth_q != '0) && (stack_q[0] == default_q))
    else $error("layer change without default layer at stack bottom");

  // a finished result waits while the output register is still full
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_OUT) && out_valid_q && out_stall_i) |=> (state_q == S_OUT))
    else $error("result overwrote a stalled output item");
`endif

endmodule
